>>> sv/salc_pkg.sv
// Shared constants and types for the set-associative LRU cache lookup.
package salc_pkg;

	// Fixed field widths of the item ports
	localparam int ADDR_W    = 32;
	localparam int OUT_WAY_W = 2;
	localparam int CNT_W     = 32;

	// Saturation value of the hit and miss counters
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Lookup decision flags from the replacement logic
	typedef struct packed {
		logic hit;
		logic evicted;
	} salc_flags_t;

endpackage

>>> sv/salc_set_index.sv
// Set index unit: address modulo the number of sets.
module salc_set_index #(
	parameter int NUM_SETS = 64,
	parameter int AW       = 32,
	localparam int SW      = $clog2(NUM_SETS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [AW-1:0] addr,
	output logic          done,
	output logic [SW-1:0] set_idx
);

	localparam bit POW2 = ((NUM_SETS & (NUM_SETS - 1)) == 0);
	localparam int CH   = 12;

	// Residue of 2^(CH*n) modulo the set count, evaluated at elaboration
	function automatic int unsigned chunk_weight(input int n);
		int unsigned c;
		c = 1;
		for (int i = 0; i < n; i++) begin
			c = (c << CH) % NUM_SETS;
		end
		return c;
	endfunction

	generate
		if (POW2) begin : g_mask
			logic [SW-1:0] set_q;
			logic          done_q;

			// Take the low address bits as the set
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					set_q <= SW'(addr);
				end
			end

			assign done    = done_q;
			assign set_idx = set_q;
		end else begin : g_recip
			localparam int NCH = (AW + CH - 1) / CH;
			localparam int PW  = NCH * CH;
			localparam int FW  = 27;
			localparam int SH  = FW + SW;
			localparam int RBW = FW + 2;
			localparam int QW  = FW + 1 - SW;
			localparam int PRW = FW + RBW;
			localparam logic [RBW-1:0] RECIP =
				RBW'(((64'd1 << SH) + 64'(NUM_SETS) - 64'd1) / 64'(NUM_SETS));

			logic [PW-1:0]          addr_pad;
			logic [NCH-1:0][FW-1:0] part;
			logic [FW-1:0]          fold_d;
			logic [FW-1:0]          fold_s1;
			logic [FW-1:0]          fold_s2;
			logic [PRW-1:0]         prod;
			logic [QW-1:0]          quot_s2;
			logic [FW-1:0]          qm;
			logic [SW-1:0]          rem_q;
			logic                   vld_s1;
			logic                   vld_s2;
			logic                   done_q;

			assign addr_pad = PW'(addr);

			// Weight each address chunk by its residue
			for (genvar g = 0; g < NCH; g++) begin : g_fold
				localparam int unsigned WT = chunk_weight(g);
				assign part[g] = FW'(addr_pad[g*CH +: CH]) * FW'(WT);
			end

			// Fold the weighted chunks into one congruent value
			always_comb begin
				fold_d = '0;
				for (int i = 0; i < NCH; i++) begin
					fold_d = fold_d + part[i];
				end
			end

			// Quotient by reciprocal multiplication, remainder by subtraction
			assign prod = PRW'(fold_s1) * PRW'(RECIP);
			assign qm   = FW'(quot_s2) * FW'(NUM_SETS);

			// Advance the valid flags through the three stages
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s1 <= 1'b0;
					vld_s2 <= 1'b0;
					done_q <= 1'b0;
				end else begin
					vld_s1 <= start;
					vld_s2 <= vld_s1;
					done_q <= vld_s2;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					fold_s1 <= fold_d;
				end
				if (vld_s1) begin
					fold_s2 <= fold_s1;
					quot_s2 <= prod[SH +: QW];
				end
				if (vld_s2) begin
					rem_q <= SW'(fold_s2 - qm);
				end
			end

			assign done    = done_q;
			assign set_idx = rem_q;
		end
	endgenerate

endmodule

>>> sv/salc_replace.sv
// Way compare, victim choice and recency update for one set.
module salc_replace import salc_pkg::*; #(
	parameter int WAYS = 4,
	parameter int AW   = 32,
	parameter int RW   = 2
) (
	input  logic [AW-1:0]             addr,
	input  logic [WAYS-1:0][AW-1:0]   tags,
	input  logic [WAYS-1:0]           valids,
	input  logic [WAYS-1:0][RW-1:0]   ranks,
	output salc_flags_t               flags,
	output logic [RW-1:0]             chosen,
	output logic [WAYS-1:0][RW-1:0]   ranks_new,
	output logic [AW-1:0]             ev_tag
);

	logic          hit_any;
	logic          inv_any;
	logic [RW-1:0] hit_w;
	logic [RW-1:0] inv_w;
	logic [RW-1:0] lru_w;
	logic [RW-1:0] old_rank;

	// Find the lowest matching, invalid and least recent ways
	always_comb begin
		hit_any = 1'b0;
		inv_any = 1'b0;
		hit_w   = '0;
		inv_w   = '0;
		lru_w   = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (valids[w] && tags[w] == addr) begin
				hit_any = 1'b1;
				hit_w   = RW'(w);
			end
			if (!valids[w]) begin
				inv_any = 1'b1;
				inv_w   = RW'(w);
			end
			if (ranks[w] == '0) begin
				lru_w = RW'(w);
			end
		end
	end

	// Pick the way: hit, else first free, else least recent
	assign chosen        = hit_any ? hit_w : (inv_any ? inv_w : lru_w);
	assign flags.hit     = hit_any;
	assign flags.evicted = !hit_any && !inv_any;
	assign ev_tag        = flags.evicted ? tags[chosen] : '0;
	assign old_rank      = ranks[chosen];

	// Promote the chosen way, close the gap above its old rank
	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			ranks_new[w] = (ranks[w] > old_rank) ? ranks[w] - 1'b1 : ranks[w];
		end
		ranks_new[chosen] = RW'(WAYS - 1);
	end

endmodule

>>> sv/set_associative_lru_cache_lookup.sv
// Set-associative cache lookup with LRU replacement, one access per beat.
// The set index unit sets the delay from accept to result valid; its registered path is
//   shorter when NUM_SETS is a power of two than the reciprocal path used otherwise.
// Only one access is in flight at a time: input stalls until the last lookup is done.
// Reset: a clearing pass over all NUM_SETS rows rewrites valid and recency rows;
//   input stays stalled until it ends. Tag RAM is not cleared.
module set_associative_lru_cache_lookup import salc_pkg::*; #(
	parameter int NUM_SETS     = 64,
	parameter int WAYS         = 4,
	parameter int ADDRESS_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [ADDR_W-1:0]    address,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 hit,
	output logic [OUT_WAY_W-1:0] way,
	output logic                 evicted,
	output logic [ADDR_W-1:0]    evicted_address,
	output logic [CNT_W-1:0]     hit_total,
	output logic [CNT_W-1:0]     miss_total
);

	localparam int AW = ADDRESS_BITS;
	localparam int SW = $clog2(NUM_SETS);
	localparam int RW = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int MW = WAYS + WAYS * RW;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_INDEX,
		S_LOOKUP
	} state_t;

	state_t state_q;

	logic [SW-1:0] clr_q;
	logic [SW-1:0] set_q;
	logic [AW-1:0] addr_q;
	logic          out_valid_q;
	logic          hit_q;
	logic          evicted_q;
	logic [OUT_WAY_W-1:0] way_q;
	logic [ADDR_W-1:0]    ev_addr_q;
	logic [CNT_W-1:0]     hit_cnt_q;
	logic [CNT_W-1:0]     miss_cnt_q;

	logic                    accept;
	logic                    idx_done;
	logic [SW-1:0]           idx;
	logic                    rd_en;
	logic                    lookup_go;
	logic                    meta_we;
	logic [SW-1:0]           meta_wa;
	logic [MW-1:0]           meta_wd;
	logic [MW-1:0]           meta_clr;
	logic [MW-1:0]           meta_rd_q;
	logic [WAYS-1:0][AW-1:0] tag_rd_q;
	logic [WAYS-1:0][AW-1:0] tag_new;
	logic [WAYS-1:0]         valid_rd;
	logic [WAYS-1:0]         valid_new;
	logic [WAYS-1:0][RW-1:0] rank_rd;
	logic [WAYS-1:0][RW-1:0] rank_new;
	logic [WAYS-1:0][RW-1:0] rank_init;
	logic [RW-1:0]           chosen;
	logic [AW-1:0]           ev_tag;
	salc_flags_t             flags;

	// Metadata and tag RAMs, one row per set
	logic [MW-1:0]           meta_mem [NUM_SETS];
	logic [WAYS-1:0][AW-1:0] tag_mem  [NUM_SETS];

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign rd_en     = (state_q == S_INDEX) && idx_done;
	assign lookup_go = (state_q == S_LOOKUP) && (!out_valid_q || !out_stall);

	salc_set_index #(
		.NUM_SETS (NUM_SETS),
		.AW       (AW)
	) u_set_index (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept),
		.addr    (AW'(address)),
		.done    (idx_done),
		.set_idx (idx)
	);

	// Unpack the metadata row
	assign valid_rd = meta_rd_q[MW-1 -: WAYS];
	assign rank_rd  = meta_rd_q[WAYS*RW-1:0];

	salc_replace #(
		.WAYS (WAYS),
		.AW   (AW),
		.RW   (RW)
	) u_replace (
		.addr      (addr_q),
		.tags      (tag_rd_q),
		.valids    (valid_rd),
		.ranks     (rank_rd),
		.flags     (flags),
		.chosen    (chosen),
		.ranks_new (rank_new),
		.ev_tag    (ev_tag)
	);

	// Build reset and updated rows
	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			rank_init[w] = RW'(w);
		end
		valid_new         = valid_rd;
		valid_new[chosen] = 1'b1;
		tag_new           = tag_rd_q;
		tag_new[chosen]   = addr_q;
	end

	assign meta_clr = {{WAYS{1'b0}}, rank_init};
	assign meta_we  = (state_q == S_CLEAR) || lookup_go;
	assign meta_wa  = (state_q == S_CLEAR) ? clr_q : set_q;
	assign meta_wd  = (state_q == S_CLEAR) ? meta_clr : {valid_new, rank_new};

	// Metadata RAM: clear sweep or write back after lookup
	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[meta_wa] <= meta_wd;
		end
		if (rd_en) begin
			meta_rd_q <= meta_mem[idx];
		end
	end

	// Tag RAM: write the new address on a miss
	always_ff @(posedge clk) begin
		if (lookup_go && !flags.hit) begin
			tag_mem[set_q] <= tag_new;
		end
		if (rd_en) begin
			tag_rd_q <= tag_mem[idx];
		end
	end

	// Sequence clear, index, lookup; hold result and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			set_q       <= '0;
			addr_q      <= '0;
			out_valid_q <= 1'b0;
			hit_q       <= 1'b0;
			evicted_q   <= 1'b0;
			way_q       <= '0;
			ev_addr_q   <= '0;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
		end else begin
			if (lookup_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SW'(NUM_SETS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						addr_q  <= AW'(address);
						state_q <= S_INDEX;
					end
				end
				S_INDEX: begin
					if (idx_done) begin
						set_q   <= idx;
						state_q <= S_LOOKUP;
					end
				end
				S_LOOKUP: begin
					if (lookup_go) begin
						hit_q     <= flags.hit;
						evicted_q <= flags.evicted;
						way_q     <= OUT_WAY_W'(chosen);
						ev_addr_q <= ADDR_W'(ev_tag);
						if (flags.hit) begin
							if (hit_cnt_q != CNT_MAX) begin
								hit_cnt_q <= hit_cnt_q + 1'b1;
							end
						end else begin
							if (miss_cnt_q != CNT_MAX) begin
								miss_cnt_q <= miss_cnt_q + 1'b1;
							end
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign hit             = hit_q;
	assign way             = way_q;
	assign evicted         = evicted_q;
	assign evicted_address = ev_addr_q;
	assign hit_total       = hit_cnt_q;
	assign miss_total      = miss_cnt_q;

	// A new result only comes out of a lookup
	a_result_from_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_LOOKUP))
		else $error("result raised without a lookup");

	// A beat never reports both a hit and an eviction
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(hit_q && evicted_q))
		else $error("hit reported together with eviction");

	// Counters change only with a new result, by at most one in total
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(hit_cnt_q) || !$stable(miss_cnt_q) |-> $past(lookup_go))
		else $error("counter moved outside a lookup");

	// No RAM read while the clear sweep runs
	a_no_read_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !rd_en && in_stall)
		else $error("access during clearing pass");

endmodule

>>> tb/sv/tb_set_associative_lru_cache_lookup.sv
// Self-checking testbench for the set-associative LRU cache lookup.
module tb_set_associative_lru_cache_lookup;
	import salc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_SETS     = 64;
	localparam int WAYS         = 4;
	localparam int ADDRESS_BITS = 32;
	localparam int SET_BITS     = $clog2(NUM_SETS);
	localparam int PHASE_ITEMS  = 317;
	localparam int SHOWN_ERRORS = 10;

	typedef struct packed {
		logic                 hit;
		logic [OUT_WAY_W-1:0] way;
		logic                 evicted;
		logic [ADDR_W-1:0]    evicted_address;
		logic [CNT_W-1:0]     hit_total;
		logic [CNT_W-1:0]     miss_total;
	} lookup_result_t;

	// Tracks cache contents and recency, and checks each result beat in order
	class lru_cache_scoreboard;
		logic [ADDR_W-1:0] tags [NUM_SETS][WAYS];
		bit                valid [NUM_SETS][WAYS];
		int unsigned       rank [NUM_SETS][WAYS];
		logic [CNT_W-1:0]  hit_count;
		logic [CNT_W-1:0]  miss_count;
		lookup_result_t    expected_q[$];
		int unsigned       errors;

		function new();
			for (int s = 0; s < NUM_SETS; s++) begin
				for (int w = 0; w < WAYS; w++) begin
					tags[s][w]  = '0;
					valid[s][w] = 1'b0;
					rank[s][w]  = w;
				end
			end
			hit_count  = '0;
			miss_count = '0;
			errors     = 0;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		// Look up one accepted address and queue the result it must produce
		function void note_access(input logic [ADDR_W-1:0] addr);
			int unsigned    set_idx;
			int unsigned    pick;
			int unsigned    old_rank;
			bit             matched;
			bit             found;
			lookup_result_t r;
			set_idx = addr % NUM_SETS;
			matched = 1'b0;
			found   = 1'b0;
			pick    = 0;
			r       = '0;
			for (int w = 0; w < WAYS; w++) begin
				if (valid[set_idx][w] && tags[set_idx][w] == addr) begin
					matched = 1'b1;
					pick    = w;
					break;
				end
			end
			if (matched) begin
				if (hit_count != CNT_MAX)
					hit_count++;
			end else begin
				if (miss_count != CNT_MAX)
					miss_count++;
				// fill the lowest free way, else replace the least recent one
				for (int w = 0; w < WAYS; w++) begin
					if (!valid[set_idx][w]) begin
						pick  = w;
						found = 1'b1;
						break;
					end
				end
				if (!found) begin
					for (int w = 0; w < WAYS; w++) begin
						if (rank[set_idx][w] == 0) begin
							pick = w;
							break;
						end
					end
					r.evicted         = 1'b1;
					r.evicted_address = tags[set_idx][pick];
				end
				tags[set_idx][pick]  = addr;
				valid[set_idx][pick] = 1'b1;
			end
			// promote the chosen way to most recent, shift the newer ones down
			old_rank = rank[set_idx][pick];
			for (int w = 0; w < WAYS; w++) begin
				if (rank[set_idx][w] > old_rank)
					rank[set_idx][w]--;
			end
			rank[set_idx][pick] = WAYS - 1;
			r.hit        = matched;
			r.way        = OUT_WAY_W'(pick);
			r.hit_total  = hit_count;
			r.miss_total = miss_count;
			expected_q.insert(expected_q.size(), r);
		endfunction

		// Compare one result beat against the oldest expectation
		function void check_result(input lookup_result_t got);
			lookup_result_t exp_r;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= SHOWN_ERRORS)
					$display("%0t: unexpected result beat hit=%b way=%0d ev=%b ev_addr=%h",
						$realtime, got.hit, got.way, got.evicted, got.evicted_address);
				return;
			end
			exp_r = expected_q[0];
			expected_q.delete(0);
			if (got.hit !== exp_r.hit || got.way !== exp_r.way ||
					got.evicted !== exp_r.evicted ||
					got.evicted_address !== exp_r.evicted_address ||
					got.hit_total !== exp_r.hit_total ||
					got.miss_total !== exp_r.miss_total) begin
				errors++;
				if (errors <= SHOWN_ERRORS) begin
					$display("%0t: result mismatch", $realtime);
					$display("  expected hit=%b way=%0d ev=%b ev_addr=%h hits=%0d misses=%0d",
						exp_r.hit, exp_r.way, exp_r.evicted, exp_r.evicted_address,
						exp_r.hit_total, exp_r.miss_total);
					$display("  actual   hit=%b way=%0d ev=%b ev_addr=%h hits=%0d misses=%0d",
						got.hit, got.way, got.evicted, got.evicted_address,
						got.hit_total, got.miss_total);
				end
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [ADDR_W-1:0]    address;
	logic                 out_valid;
	logic                 out_stall;
	logic                 hit;
	logic [OUT_WAY_W-1:0] way;
	logic                 evicted;
	logic [ADDR_W-1:0]    evicted_address;
	logic [CNT_W-1:0]     hit_total;
	logic [CNT_W-1:0]     miss_total;

	lru_cache_scoreboard board = new();
	lookup_result_t      seen_result;
	int unsigned         send_gap_pct;
	int unsigned         recv_stall_pct;
	logic [ADDR_W-1:0]   recent_addrs[$];
	logic [ADDR_W-1:0]   hot_tags [6];
	int unsigned         hot_sets [4];

	set_associative_lru_cache_lookup #(
		.NUM_SETS    (NUM_SETS),
		.WAYS        (WAYS),
		.ADDRESS_BITS(ADDRESS_BITS)
	) u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.address        (address),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.hit            (hit),
		.way            (way),
		.evicted        (evicted),
		.evicted_address(evicted_address),
		.hit_total      (hit_total),
		.miss_total     (miss_total)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stall the result side at random on each falling edge
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Check every result beat taken at a rising edge
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen_result.hit             = hit;
			seen_result.way             = way;
			seen_result.evicted         = evicted;
			seen_result.evicted_address = evicted_address;
			seen_result.hit_total       = hit_total;
			seen_result.miss_total      = miss_total;
			board.check_result(seen_result);
		end
	end

	// Present one access beat, with random idle cycles ahead of it; call at a falling edge
	task automatic issue_access(input logic [ADDR_W-1:0] addr);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		address  <= addr;
		do
			@(posedge clk);
		while (in_stall);
		board.note_access(addr);
		recent_addrs.insert(recent_addrs.size(), addr);
		if (recent_addrs.size() > 16)
			recent_addrs.delete(0);
		@(negedge clk);
	endtask

	// Hold the input idle until every queued result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(negedge clk);
	endtask

	// Pick a random access: mostly reuse and crowded sets, some fully random
	function automatic logic [ADDR_W-1:0] pick_address();
		int unsigned       roll;
		logic [ADDR_W-1:0] tag_part;
		roll = $urandom_range(99);
		if (roll < 45) begin
			tag_part = hot_tags[$urandom_range(5)];
			return (tag_part << SET_BITS) | ADDR_W'(hot_sets[$urandom_range(3)]);
		end else if (roll < 75 && recent_addrs.size() != 0) begin
			return recent_addrs[$urandom_range(recent_addrs.size() - 1)];
		end
		return $urandom;
	endfunction

	// Main sequence: reset, directed accesses, then three random phases
	initial begin
		logic [ADDR_W-1:0] set5 [5];
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		address        = '0;
		out_stall      = 1'b0;
		send_gap_pct   = 23;
		recv_stall_pct = 60;
		hot_sets       = '{0, 17, 42, NUM_SETS - 1};
		foreach (hot_tags[i])
			hot_tags[i] = $urandom;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// fill all four ways of one set, reorder by hits, then force evictions
		for (int i = 0; i < 5; i++)
			set5[i] = 32'd5 + 32'(i * NUM_SETS);
		for (int i = 0; i < 4; i++)
			issue_access(set5[i]);
		issue_access(set5[1]);
		issue_access(set5[0]);
		issue_access(set5[4]);
		issue_access(set5[2]);
		issue_access(set5[0]);
		issue_access(set5[3]);
		// address extremes, and a full last set with an eviction
		issue_access(32'h0000_0000);
		issue_access(32'h0000_0000);
		issue_access(32'hFFFF_FFFF);
		issue_access(32'hFFFF_FFFF);
		issue_access(32'hFFFF_FFBF);
		issue_access(32'h7FFF_FFFF);
		issue_access(32'h0000_003F);
		issue_access(32'h8000_003F);
		issue_access(32'hFFFF_FFFF);
		issue_access(32'hFFFF_FFC0);
		issue_access(32'hAAAA_AAAA);
		issue_access(32'h5555_5555);
		drain_results();

		// sender idles less than receiver
		for (int i = 0; i < PHASE_ITEMS; i++)
			issue_access(pick_address());
		drain_results();

		// receiver idles less than sender
		send_gap_pct   = 60;
		recv_stall_pct = 23;
		for (int i = 0; i < PHASE_ITEMS; i++)
			issue_access(pick_address());
		drain_results();

		// back-to-back traffic, no idling on either side
		send_gap_pct   = 0;
		recv_stall_pct = 0;
		for (int i = 0; i < PHASE_ITEMS; i++)
			issue_access(pick_address());
		in_valid <= 1'b0;

		while (board.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Give up if the run stalls
	initial begin
		#3_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> set_associative_lru_cache_lookup.f
sv/salc_pkg.sv
sv/salc_set_index.sv
sv/salc_replace.sv
sv/set_associative_lru_cache_lookup.sv
tb/sv/tb_set_associative_lru_cache_lookup.sv
